FILE: rtl/core/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types and field widths for the priority schedule timing core.
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int BURST_W = 16;
  localparam int PRI_W   = 8;
  localparam int NUM_W   = 6;
  localparam int TIME_W  = 21;

  typedef struct packed {
    logic [NUM_W-1:0]   num;
    logic [PRI_W-1:0]   pri;
    logic [BURST_W-1:0] burst;
  } pst_rec_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_I_RD,
    S_I_GET,
    S_J_RD,
    S_J_GET,
    S_SW1,
    S_SW2,
    S_E_RD,
    S_E_GET,
    S_DIV_W,
    S_DIV_T,
    S_E_OUT
  } pst_state_t;

endpackage

FILE: rtl/core/pst_mem.sv
// ----------------------------------------------------------------------------
// pst_mem
// Record store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pst_mem
  import pst_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  pst_rec_t                 wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output pst_rec_t                 rdata
);

  pst_rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/pst_div.sv
// ----------------------------------------------------------------------------
// pst_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pst_div #(
  parameter int DVD_W = 28,
  parameter int DVS_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] q_r, q_nxt;
  logic [DVS_W:0]   rem_r, rem_nxt;
  logic [DVS_W-1:0] d_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [DVS_W+1:0] trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[DVD_W-1]};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CW'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {2'b00, d_r}) begin
        rem_nxt = (DVS_W+1)'(trial - {2'b00, d_r});
        q_nxt   = {q_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = (DVS_W+1)'(trial);
        q_nxt   = {q_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (start) begin
      d_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: rtl/core/priority_schedule_timing_core.sv
// ----------------------------------------------------------------------------
// priority_schedule_timing_core
// Non-preemptive priority scheduler: collects process requests, selection
// sorts them by priority in a record store, then emits timing per process.
// ----------------------------------------------------------------------------
// Load: one request per cycle while in the load state. After the last request
// the store is sorted by one comparator: each scanned slot is read and
// compared, and every pass ends in a swap of two writes. Each result is then
// read and registered; the final one also waits on two divider passes.
// Reset (rst_n, synchronous) empties the run; the store needs no clearing.
// ----------------------------------------------------------------------------
module priority_schedule_timing_core
  import pst_pkg::*;
#(
  parameter int MAX_PROCESSES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BURST_W-1:0] in_burst_time,
  input  logic [PRI_W-1:0]  in_priority_level,
  input  logic              in_last_process,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [NUM_W-1:0]  out_process_number,
  output logic [BURST_W-1:0] out_burst_out,
  output logic [PRI_W-1:0]  out_priority_out,
  output logic [TIME_W-1:0] out_waiting_time,
  output logic [TIME_W-1:0] out_turnaround_time,
  output logic [TIME_W-1:0] out_average_waiting,
  output logic [TIME_W-1:0] out_average_turnaround,
  output logic              out_overflow_seen,
  output logic              out_last_result
);

  localparam int IDX_W  = $clog2(MAX_PROCESSES);
  localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);
  localparam int WAIT_W = BURST_W + CNT_W;   // sum of up to MAX bursts
  localparam int SUM_W  = WAIT_W + CNT_W;    // sum of up to MAX waits

  pst_state_t state_r, state_nxt;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;       // records held, n during sort/emit
  logic              ovf_r, ovf_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  pst_rec_t          irec_r, irec_nxt, minrec_r, minrec_nxt;
  logic [WAIT_W-1:0] wait_r, wait_nxt;
  logic [SUM_W-1:0]  sumw_r, sumw_nxt, sumt_r, sumt_nxt;
  logic [WAIT_W-1:0] tat;

  // result registers
  logic [NUM_W-1:0]   o_num_r, o_num_nxt;
  logic [BURST_W-1:0] o_burst_r, o_burst_nxt;
  logic [PRI_W-1:0]   o_pri_r, o_pri_nxt;
  logic [TIME_W-1:0]  o_wait_r, o_wait_nxt, o_tat_r, o_tat_nxt;
  logic [TIME_W-1:0]  o_avgw_r, o_avgw_nxt, o_avgt_r, o_avgt_nxt;
  logic               o_last_r, o_last_nxt;

  // store ports
  logic              we;
  logic [IDX_W-1:0]  waddr, raddr;
  pst_rec_t          wdata, rdata;

  // divider ports
  logic              div_start, div_done;
  logic [SUM_W-1:0]  div_dvd, div_q;

  logic [CNT_W-1:0]  i_inc, j_inc, k_inc;

  pst_mem #(.DEPTH(MAX_PROCESSES)) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  pst_div #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dvd),
    .divisor (cnt_r),
    .done    (div_done),
    .quotient(div_q)
  );

  assign in_ready = (state_r == S_LOAD);
  assign i_inc    = i_r + 1'b1;
  assign j_inc    = j_r + 1'b1;
  assign k_inc    = k_r + 1'b1;
  assign tat      = wait_r + WAIT_W'(rdata.burst);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    pos_nxt    = pos_r;
    irec_nxt   = irec_r;
    minrec_nxt = minrec_r;
    wait_nxt   = wait_r;
    sumw_nxt   = sumw_r;
    sumt_nxt   = sumt_r;
    o_num_nxt   = o_num_r;
    o_burst_nxt = o_burst_r;
    o_pri_nxt   = o_pri_r;
    o_wait_nxt  = o_wait_r;
    o_tat_nxt   = o_tat_r;
    o_avgw_nxt  = o_avgw_r;
    o_avgt_nxt  = o_avgt_r;
    o_last_nxt  = o_last_r;
    we         = 1'b0;
    waddr      = cnt_r[IDX_W-1:0];
    wdata      = '{num: NUM_W'({1'b0, cnt_r} + 1'b1),
                   pri: in_priority_level, burst: in_burst_time};
    raddr      = i_r[IDX_W-1:0];
    div_start  = 1'b0;
    div_dvd    = sumw_nxt;

    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (cnt_r < CNT_W'(MAX_PROCESSES)) begin
            we      = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_process) begin
            i_nxt     = '0;
            state_nxt = S_I_RD;
          end
        end
      end
      S_I_RD: begin
        raddr     = i_r[IDX_W-1:0];
        state_nxt = S_I_GET;
      end
      S_I_GET: begin
        irec_nxt   = rdata;
        minrec_nxt = rdata;
        pos_nxt    = i_r[IDX_W-1:0];
        j_nxt      = i_inc;
        state_nxt  = (i_inc >= cnt_r) ? S_SW1 : S_J_RD;
      end
      S_J_RD: begin
        raddr     = j_r[IDX_W-1:0];
        state_nxt = S_J_GET;
      end
      S_J_GET: begin
        // first minimum wins: strict less-than
        if (rdata.pri < minrec_r.pri) begin
          minrec_nxt = rdata;
          pos_nxt    = j_r[IDX_W-1:0];
        end
        j_nxt     = j_inc;
        state_nxt = (j_inc >= cnt_r) ? S_SW1 : S_J_RD;
      end
      S_SW1: begin
        we        = 1'b1;
        waddr     = i_r[IDX_W-1:0];
        wdata     = minrec_r;
        state_nxt = S_SW2;
      end
      S_SW2: begin
        we    = 1'b1;
        waddr = pos_r;
        wdata = irec_r;
        i_nxt = i_inc;
        if (i_inc >= cnt_r) begin
          k_nxt     = '0;
          wait_nxt  = '0;
          sumw_nxt  = '0;
          sumt_nxt  = '0;
          state_nxt = S_E_RD;
        end else begin
          state_nxt = S_I_RD;
        end
      end
      S_E_RD: begin
        raddr     = k_r[IDX_W-1:0];
        state_nxt = S_E_GET;
      end
      S_E_GET: begin
        o_num_nxt   = rdata.num;
        o_burst_nxt = rdata.burst;
        o_pri_nxt   = rdata.pri;
        o_wait_nxt  = TIME_W'(wait_r);
        o_tat_nxt   = TIME_W'(tat);
        o_avgw_nxt  = '0;
        o_avgt_nxt  = '0;
        sumw_nxt    = sumw_r + SUM_W'(wait_r);
        sumt_nxt    = sumt_r + SUM_W'(tat);
        wait_nxt    = tat;
        o_last_nxt  = (k_inc == cnt_r);
        if (k_inc == cnt_r) begin
          div_start = 1'b1;
          div_dvd   = sumw_nxt;
          state_nxt = S_DIV_W;
        end else begin
          state_nxt = S_E_OUT;
        end
      end
      S_DIV_W: begin
        if (div_done) begin
          o_avgw_nxt = TIME_W'(div_q);
          div_start  = 1'b1;
          div_dvd    = sumt_r;
          state_nxt  = S_DIV_T;
        end
      end
      S_DIV_T: begin
        if (div_done) begin
          o_avgt_nxt = TIME_W'(div_q);
          state_nxt  = S_E_OUT;
        end
      end
      S_E_OUT: begin
        if (out_ready) begin
          if (o_last_r) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_inc;
            state_nxt = S_E_RD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    k_r       <= k_nxt;
    pos_r     <= pos_nxt;
    irec_r    <= irec_nxt;
    minrec_r  <= minrec_nxt;
    wait_r    <= wait_nxt;
    sumw_r    <= sumw_nxt;
    sumt_r    <= sumt_nxt;
    o_num_r   <= o_num_nxt;
    o_burst_r <= o_burst_nxt;
    o_pri_r   <= o_pri_nxt;
    o_wait_r  <= o_wait_nxt;
    o_tat_r   <= o_tat_nxt;
    o_avgw_r  <= o_avgw_nxt;
    o_avgt_r  <= o_avgt_nxt;
    o_last_r  <= o_last_nxt;
  end

  assign out_valid              = (state_r == S_E_OUT);
  assign out_process_number     = o_num_r;
  assign out_burst_out          = o_burst_r;
  assign out_priority_out       = o_pri_r;
  assign out_waiting_time       = o_wait_r;
  assign out_turnaround_time    = o_tat_r;
  assign out_average_waiting    = o_avgw_r;
  assign out_average_turnaround = o_avgt_r;
  assign out_overflow_seen      = ovf_r;
  assign out_last_result        = o_last_r;

endmodule

FILE: tb/pst_checker.sv
// ----------------------------------------------------------------------------
// pst_checker
// Watches the request and result channels, keeps its own schedule model and
// compares every result, all fields at once; reports a failure count.
// ----------------------------------------------------------------------------
module pst_checker
  import pst_pkg::*;
#(
  parameter int MAX_PROCESSES = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [BURST_W-1:0] in_burst_time,
  input  logic [PRI_W-1:0]   in_priority_level,
  input  logic               in_last_process,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [NUM_W-1:0]   out_process_number,
  input  logic [BURST_W-1:0] out_burst_out,
  input  logic [PRI_W-1:0]   out_priority_out,
  input  logic [TIME_W-1:0]  out_waiting_time,
  input  logic [TIME_W-1:0]  out_turnaround_time,
  input  logic [TIME_W-1:0]  out_average_waiting,
  input  logic [TIME_W-1:0]  out_average_turnaround,
  input  logic               out_overflow_seen,
  input  logic               out_last_result,
  output int                 fail_count,
  output int                 pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [NUM_W-1:0]   num;
    logic [BURST_W-1:0] burst;
    logic [PRI_W-1:0]   pri;
    logic [TIME_W-1:0]  wait_t;
    logic [TIME_W-1:0]  tat;
    logic [TIME_W-1:0]  avg_wait;
    logic [TIME_W-1:0]  avg_tat;
    logic               ovf;
    logic               last;
  } sched_result_t;

  pst_rec_t      held_recs[MAX_PROCESSES];
  int            held_count;
  bit            dropped;
  sched_result_t schedule_q[$];

  task automatic take_request(input logic [BURST_W-1:0] b, input logic [PRI_W-1:0] p,
                              input logic last);
    pst_rec_t      tmp;
    int            pos;
    longint        w, sum_w, sum_t;
    sched_result_t r;
    if (held_count < MAX_PROCESSES) begin
      held_recs[held_count] = '{num: NUM_W'(held_count + 1), pri: p, burst: b};
      held_count++;
    end else begin
      dropped = 1'b1;
    end
    if (!last) return;
    // selection sort with swaps: ties keep this exact unstable order
    for (int i = 0; i < held_count; i++) begin
      pos = i;
      for (int j = i + 1; j < held_count; j++)
        if (held_recs[j].pri < held_recs[pos].pri) pos = j;
      tmp = held_recs[i];
      held_recs[i] = held_recs[pos];
      held_recs[pos] = tmp;
    end
    w = 0; sum_w = 0; sum_t = 0;
    for (int k = 0; k < held_count; k++) begin
      sum_w += w;
      sum_t += w + held_recs[k].burst;
      w += held_recs[k].burst;
    end
    w = 0;
    for (int k = 0; k < held_count; k++) begin
      r.num      = held_recs[k].num;
      r.burst    = held_recs[k].burst;
      r.pri      = held_recs[k].pri;
      r.wait_t   = TIME_W'(w);
      r.tat      = TIME_W'(w + held_recs[k].burst);
      r.last     = (k == held_count - 1);
      r.avg_wait = r.last ? TIME_W'(sum_w / held_count) : '0;
      r.avg_tat  = r.last ? TIME_W'(sum_t / held_count) : '0;
      r.ovf      = dropped;
      schedule_q.push_back(r);
      w += held_recs[k].burst;
    end
    held_count = 0;
    dropped = 1'b0;
  endtask

  always @(posedge clk) begin
    sched_result_t e, a;
    if (!rst_n) begin
      held_count = 0;
      dropped = 1'b0;
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        a = '{out_process_number, out_burst_out, out_priority_out, out_waiting_time,
              out_turnaround_time, out_average_waiting, out_average_turnaround,
              out_overflow_seen, out_last_result};
        if (schedule_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, a);
          fail_count++;
        end else begin
          e = schedule_q.pop_front();
          if (a !== e) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, a);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        take_request(in_burst_time, in_priority_level, in_last_process);
    end
    pending_count = schedule_q.size();
  end

endmodule

FILE: tb/tb_priority_schedule_timing_core.sv
// ----------------------------------------------------------------------------
// tb_priority_schedule_timing_core
// Drives process request sets through the scheduler under several idle and
// stall mixes; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module tb_priority_schedule_timing_core;
  import pst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXP = 32;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [BURST_W-1:0] in_burst_time;
  logic [PRI_W-1:0]   in_priority_level;
  logic               in_last_process;
  logic               out_valid;
  logic               out_ready;
  logic [NUM_W-1:0]   out_process_number;
  logic [BURST_W-1:0] out_burst_out;
  logic [PRI_W-1:0]   out_priority_out;
  logic [TIME_W-1:0]  out_waiting_time;
  logic [TIME_W-1:0]  out_turnaround_time;
  logic [TIME_W-1:0]  out_average_waiting;
  logic [TIME_W-1:0]  out_average_turnaround;
  logic               out_overflow_seen;
  logic               out_last_result;
  int                 fail_count;
  int                 pending_count;

  // idle percentages for sender and receiver, changed per phase
  int  send_idle_pct;
  int  recv_stall_pct;
  longint cycle_count = 0;

  priority_schedule_timing_core #(.MAX_PROCESSES(MAXP)) uut (.*);

  pst_checker #(.MAX_PROCESSES(MAXP)) checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: random stalls, redrawn every cycle
  always @(posedge clk) begin
    if (!rst_n)
      out_ready <= 1'b0;
    else
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog, generous against the worst sort time of full sets under stalls
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1_000_000) begin
      $display("tb_priority_schedule_timing_core: FAIL");
      $finish;
    end
  end

  // one request: optional idle gap, then hold valid until accepted;
  // valid stays up afterwards so the next request can follow directly
  task automatic send_request(input logic [BURST_W-1:0] b, input logic [PRI_W-1:0] p,
                              input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_burst_time <= b;
    in_priority_level <= p;
    in_last_process <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // a set of n random processes; narrow priorities give plenty of ties
  task automatic send_set(input int n);
    int pri_hi;
    pri_hi = ($urandom_range(1) == 0) ? 3 : 255;
    for (int i = 0; i < n; i++)
      send_request($urandom_range(3) == 0 ? 16'($urandom_range(65535, 65000))
                                          : 16'($urandom),
                   8'($urandom_range(pri_hi)), i == n - 1);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    int sent;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_burst_time = '0;
    in_priority_level = '0;
    in_last_process = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single process, extreme fields
    send_request(16'hFFFF, 8'hFF, 1'b1);
    send_request(16'h0000, 8'h00, 1'b1);
    // reverse priorities with a tie
    send_request(16'd10, 8'd9, 1'b0);
    send_request(16'd20, 8'd5, 1'b0);
    send_request(16'd30, 8'd5, 1'b0);
    send_request(16'hFFFF, 8'd0, 1'b1);
    // capacity exceeded: 34 requests, overflow carried on every result
    for (int i = 0; i < MAXP + 2; i++)
      send_request(16'hFFFF - 16'(i), 8'($urandom), i == MAXP + 1);
    drain();

    // random sets over the idle phases
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 84 : 34) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 84 : 34) : 0;
      sent = 0;
      while (sent < 16) begin
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(MAXP + 3, MAXP) : $urandom_range(6, 1);
        send_set(n);
        sent += n;
      end
      drain();
    end

    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("tb_priority_schedule_timing_core: PASS");
    else
      $display("tb_priority_schedule_timing_core: FAIL");
    $finish;
  end
endmodule
